>>> rtl/core/acx_pkg.sv
// Shared types, opcodes and sizes for the accumulator machine execute unit.
package acx_pkg;

   // MEM_WORDS is a power of two, so an address wraps by keeping its low bits.
   localparam int MEM_WORDS   = 65536;
   localparam int STACK_DEPTH = 256;
   localparam int MEM_AW      = $clog2(MEM_WORDS);
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);

   localparam logic [4:0] OP_SET    = 5'd0;
   localparam logic [4:0] OP_ADD    = 5'd1;
   localparam logic [4:0] OP_SUB    = 5'd2;
   localparam logic [4:0] OP_SHG    = 5'd3;
   localparam logic [4:0] OP_SHS    = 5'd4;
   localparam logic [4:0] OP_LOR    = 5'd5;
   localparam logic [4:0] OP_AND    = 5'd6;
   localparam logic [4:0] OP_XOR    = 5'd7;
   localparam logic [4:0] OP_NOT    = 5'd8;
   localparam logic [4:0] OP_LDA    = 5'd9;
   localparam logic [4:0] OP_LDR    = 5'd10;
   localparam logic [4:0] OP_SAD    = 5'd11;
   localparam logic [4:0] OP_SRD    = 5'd12;
   localparam logic [4:0] OP_LPA    = 5'd13;
   localparam logic [4:0] OP_LPR    = 5'd14;
   localparam logic [4:0] OP_SAP    = 5'd15;
   localparam logic [4:0] OP_SRP    = 5'd16;
   localparam logic [4:0] OP_OUT    = 5'd17;
   localparam logic [4:0] OP_INP    = 5'd18;
   localparam logic [4:0] OP_GOT    = 5'd19;
   localparam logic [4:0] OP_JM0    = 5'd20;
   localparam logic [4:0] OP_JMA    = 5'd21;
   localparam logic [4:0] OP_JMG    = 5'd22;
   localparam logic [4:0] OP_JML    = 5'd23;
   localparam logic [4:0] OP_JMS    = 5'd24;
   localparam logic [4:0] OP_RET    = 5'd25;
   localparam logic [4:0] OP_PHA    = 5'd26;
   localparam logic [4:0] OP_PLA    = 5'd27;
   localparam logic [4:0] OP_BRK    = 5'd28;
   localparam logic [4:0] OP_CLR    = 5'd29;
   localparam logic [4:0] OP_PUTSTR = 5'd30;

   typedef struct packed {
      logic [4:0]  operation;
      logic [15:0] attribute;
      logic [15:0] input_value;
   } req_type;

   typedef struct packed {
      logic [15:0] next_index;
      logic        print_valid;
      logic [15:0] print_value;
      logic        char_valid;
      logic [7:0]  char_code;
      logic [15:0] acc_value;
      logic        finished;
      logic        stack_fault;
   } rsp_type;

   // Opcodes whose first step reads the data memory at the attribute.
   function automatic logic is_mem_read(input logic [4:0] op);
      return (op == OP_LDA) || (op == OP_LDR) || (op == OP_LPA) || (op == OP_LPR) ||
             (op == OP_SAP) || (op == OP_SRP) || (op == OP_OUT);
   endfunction

   function automatic logic is_stack_pop(input logic [4:0] op);
      return (op == OP_RET) || (op == OP_PLA);
   endfunction

endpackage

>>> rtl/core/accumulator_cpu_execute_top.sv
// Execute unit of a 16-bit accumulator machine built around a data memory and a stack memory.

// One instruction word goes in on req, one result word comes out on rsp. Instructions
// without a memory read retire from the idle state; direct loads, out, indirect stores, ret
// and pla on a non-empty stack retire from ST_RD1; indirect loads from ST_RD2. The steps are
// set by the single port of the data memory and its registered read data: an indirect access
// reads the pointer, then reads or writes the target. One input word is buffered and the
// result sits in an output register, so the next word is taken while a result waits. After
// reset the data memory is cleared one word a cycle through all MEM_WORDS (65536) words, with
// req_ready low; csr writes are taken at any time but are meant for an idle unit.
module accumulator_cpu_execute_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  acx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output acx_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD1  = 2'd1;
   localparam logic [1:0] ST_RD2  = 2'd2;

   // Architectural state and control.
   logic [1:0]                 state_ff, state_in;
   logic                       item_valid_ff, item_valid_in;
   acx_pkg::req_type           item_ff, item_in;
   acx_pkg::req_type           cur_ff, cur_in;
   logic [15:0]                acc_ff, acc_in;
   logic [15:0]                reg_ff, reg_in;
   logic [15:0]                pc_ff, pc_in;
   logic                       halted_ff, halted_in;
   logic [acx_pkg::SP_W-1:0]   sp_ff, sp_in;
   logic [15:0]                len_ff, len_in;
   logic                       clearing_ff, clearing_in;
   logic [acx_pkg::MEM_AW-1:0] clr_addr_ff, clr_addr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   acx_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // Memories and their ports.
   logic [15:0]                data_mem [acx_pkg::MEM_WORDS];
   logic [15:0]                stack_mem [acx_pkg::STACK_DEPTH];
   logic [15:0]                mem_rdata_ff;
   logic [15:0]                stk_rdata_ff;
   logic                       mem_en, mem_we;
   logic [acx_pkg::MEM_AW-1:0] mem_addr;
   logic [15:0]                mem_wdata;
   logic                       stk_en, stk_we;
   logic [acx_pkg::STK_AW-1:0] stk_addr;
   logic [15:0]                stk_wdata;

   // Retire datapath.
   acx_pkg::req_type           work;
   logic [4:0]                 op;
   logic                       fin_pre, stk_empty, stk_full, out_free;
   logic                       take, retire;
   logic [15:0]                ld;
   logic [acx_pkg::SP_W-1:0]   sp_dec;
   logic [15:0]                acc_n, reg_n, pc_n;
   logic [acx_pkg::SP_W-1:0]   sp_n;
   logic                       halted_n;
   acx_pkg::rsp_type           res;

   assign work      = (state_ff == ST_IDLE) ? item_ff : cur_ff;
   assign op        = work.operation;
   assign fin_pre   = halted_ff || (pc_ff >= len_ff);
   assign stk_empty = (sp_ff == '0);
   assign stk_full  = (sp_ff >= acx_pkg::SP_W'(acx_pkg::STACK_DEPTH));
   assign sp_dec    = sp_ff - acx_pkg::SP_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ld        = acx_pkg::is_stack_pop(op) ? stk_rdata_ff : mem_rdata_ff;

   assign req_ready = !clearing_ff && (!item_valid_ff || take);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Effect of the instruction in work, given the loaded word where it needs one.
   always_comb begin
      acc_n    = acc_ff;
      reg_n    = reg_ff;
      pc_n     = pc_ff + 16'd1;
      sp_n     = sp_ff;
      halted_n = halted_ff;
      res      = '0;
      if (fin_pre) begin
         pc_n           = pc_ff;
         res.next_index = pc_ff;
         res.acc_value  = acc_ff;
         res.finished   = 1'b1;
      end else begin
         case (op)
            acx_pkg::OP_SET: reg_n = work.attribute;
            acx_pkg::OP_ADD: acc_n = acc_ff + reg_ff;
            acx_pkg::OP_SUB: acc_n = acc_ff - reg_ff;
            acx_pkg::OP_SHG: acc_n = {acc_ff[14:0], 1'b0};
            acx_pkg::OP_SHS: acc_n = {1'b0, acc_ff[15:1]};
            acx_pkg::OP_LOR: acc_n = acc_ff | reg_ff;
            acx_pkg::OP_AND: acc_n = acc_ff & reg_ff;
            acx_pkg::OP_XOR: acc_n = acc_ff ^ reg_ff;
            acx_pkg::OP_NOT: acc_n = ~acc_ff;
            acx_pkg::OP_LDA: acc_n = ld;
            acx_pkg::OP_LDR: reg_n = ld;
            acx_pkg::OP_LPA: acc_n = ld;
            acx_pkg::OP_LPR: reg_n = ld;
            acx_pkg::OP_OUT: begin
               res.print_valid = 1'b1;
               res.print_value = ld;
            end
            acx_pkg::OP_GOT: pc_n = work.attribute + 16'd1;
            acx_pkg::OP_JM0: if (acc_ff == 16'd0) pc_n = work.attribute + 16'd1;
            acx_pkg::OP_JMA: if (acc_ff == reg_ff) pc_n = work.attribute + 16'd1;
            acx_pkg::OP_JMG: if (acc_ff > reg_ff) pc_n = work.attribute + 16'd1;
            acx_pkg::OP_JML: if (acc_ff < reg_ff) pc_n = work.attribute + 16'd1;
            acx_pkg::OP_JMS: begin
               if (stk_full) res.stack_fault = 1'b1;
               else sp_n = sp_ff + acx_pkg::SP_W'(1);
               pc_n = work.attribute + 16'd1;
            end
            acx_pkg::OP_RET: begin
               if (stk_empty) begin
                  res.stack_fault = 1'b1;
               end else begin
                  sp_n = sp_dec;
                  pc_n = ld + 16'd1;
               end
            end
            acx_pkg::OP_PHA: begin
               if (stk_full) res.stack_fault = 1'b1;
               else sp_n = sp_ff + acx_pkg::SP_W'(1);
            end
            acx_pkg::OP_PLA: begin
               if (stk_empty) begin
                  acc_n = 16'd0;
               end else begin
                  sp_n  = sp_dec;
                  acc_n = ld;
               end
            end
            acx_pkg::OP_BRK: halted_n = 1'b1;
            acx_pkg::OP_CLR: begin
               acc_n = 16'd0;
               reg_n = 16'd0;
            end
            acx_pkg::OP_PUTSTR: begin
               res.char_valid = 1'b1;
               res.char_code  = acc_ff[7:0];
            end
            default: ;
         endcase
         res.next_index = pc_n;
         res.acc_value  = acc_n;
         res.finished   = halted_n || (pc_n >= len_ff);
      end
   end

   // Sequencer: issues memory accesses and decides when the instruction retires.
   always_comb begin
      state_in  = state_ff;
      take      = 1'b0;
      retire    = 1'b0;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = work.attribute[acx_pkg::MEM_AW-1:0];
      mem_wdata = acc_ff;
      stk_en    = 1'b0;
      stk_we    = 1'b0;
      stk_addr  = sp_ff[acx_pkg::STK_AW-1:0];
      stk_wdata = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid_ff) begin
               if (!fin_pre && acx_pkg::is_mem_read(op)) begin
                  take     = 1'b1;
                  mem_en   = 1'b1;
                  state_in = ST_RD1;
               end else if (!fin_pre && acx_pkg::is_stack_pop(op) && !stk_empty) begin
                  take     = 1'b1;
                  stk_en   = 1'b1;
                  stk_addr = sp_dec[acx_pkg::STK_AW-1:0];
                  state_in = ST_RD1;
               end else if (out_free) begin
                  take   = 1'b1;
                  retire = 1'b1;
                  if (!fin_pre) begin
                     case (op)
                        acx_pkg::OP_SAD: begin
                           mem_en = 1'b1;
                           mem_we = 1'b1;
                        end
                        acx_pkg::OP_SRD: begin
                           mem_en    = 1'b1;
                           mem_we    = 1'b1;
                           mem_wdata = reg_ff;
                        end
                        acx_pkg::OP_INP: begin
                           mem_en    = 1'b1;
                           mem_we    = 1'b1;
                           mem_wdata = work.input_value;
                        end
                        acx_pkg::OP_JMS: begin
                           stk_en    = !stk_full;
                           stk_we    = 1'b1;
                           stk_wdata = pc_ff;
                        end
                        acx_pkg::OP_PHA: begin
                           stk_en = !stk_full;
                           stk_we = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
         ST_RD1: begin
            mem_addr = mem_rdata_ff[acx_pkg::MEM_AW-1:0];
            if ((op == acx_pkg::OP_LPA) || (op == acx_pkg::OP_LPR)) begin
               mem_en   = 1'b1;
               state_in = ST_RD2;
            end else if (out_free) begin
               retire   = 1'b1;
               state_in = ST_IDLE;
               if ((op == acx_pkg::OP_SAP) || (op == acx_pkg::OP_SRP)) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_wdata = (op == acx_pkg::OP_SRP) ? reg_ff : acc_ff;
               end
            end
         end
         ST_RD2: begin
            if (out_free) begin
               retire   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // The clearing pass owns the data memory port; no word is taken meanwhile.
      if (clearing_ff) begin
         mem_en    = 1'b1;
         mem_we    = 1'b1;
         mem_addr  = clr_addr_ff;
         mem_wdata = 16'd0;
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_in       = req_data;
      end else if (take) begin
         item_valid_in = 1'b0;
      end
      cur_in = take ? item_ff : cur_ff;

      acc_in    = retire ? acc_n : acc_ff;
      reg_in    = retire ? reg_n : reg_ff;
      pc_in     = retire ? pc_n : pc_ff;
      sp_in     = retire ? sp_n : sp_ff;
      halted_in = retire ? halted_n : halted_ff;

      len_in = (csr_valid && csr_ready) ? csr_data : len_ff;

      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         if (clr_addr_ff == acx_pkg::MEM_AW'(acx_pkg::MEM_WORDS - 1)) clearing_in = 1'b0;
         clr_addr_in = clr_addr_ff + acx_pkg::MEM_AW'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (retire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         item_valid_ff <= 1'b0;
         acc_ff        <= 16'd0;
         reg_ff        <= 16'd0;
         pc_ff         <= 16'd0;
         halted_ff     <= 1'b0;
         sp_ff         <= '0;
         len_ff        <= 16'hFFFF;
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_valid_ff <= item_valid_in;
         acc_ff        <= acc_in;
         reg_ff        <= reg_in;
         pc_ff         <= pc_in;
         halted_ff     <= halted_in;
         sp_ff         <= sp_in;
         len_ff        <= len_in;
         clearing_ff   <= clearing_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Data memory: one port, read data registered and held until the next read.
   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) data_mem[mem_addr] <= mem_wdata;
         else mem_rdata_ff <= data_mem[mem_addr];
      end
   end

   // Stack memory: one port, same timing as the data memory.
   always_ff @(posedge clock) begin
      if (stk_en) begin
         if (stk_we) stack_mem[stk_addr] <= stk_wdata;
         else stk_rdata_ff <= stack_mem[stk_addr];
      end
   end

endmodule

>>> tb/sv/accumulator_cpu_execute_top_tb.sv
// Self-checking testbench for the accumulator machine execute unit, with its own instruction model.
module accumulator_cpu_execute_top_tb;

   localparam logic [4:0] OP_UNUSED    = 5'd31;
   localparam int         RANDOM_ITEMS = 1550;
   localparam int         CALM_ITEMS   = 200;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         LIMIT_CYCLES = 700000;

   typedef enum int {MIX_STYLE, FILL_STYLE, DRAIN_STYLE} burst_style_type;

   typedef struct {
      bit               is_cfg;
      bit               typed;
      acx_pkg::req_type word;
      logic [15:0]      cfg_value;
      acx_pkg::rsp_type want;
   } plan_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   acx_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   acx_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [15:0]      csr_data  = '0;

   // Machine state as the model sees it.
   logic [15:0] m_acc    = '0;
   logic [15:0] m_reg    = '0;
   logic [15:0] m_pc     = '0;
   logic [15:0] m_len    = 16'hFFFF;
   bit          m_halted = 1'b0;
   int          m_sp     = 0;
   logic [15:0] m_mem   [0:acx_pkg::MEM_WORDS-1];
   logic [15:0] m_stack [0:acx_pkg::STACK_DEPTH-1];

   acx_pkg::rsp_type pending_results[$];
   plan_row_type     plan_rows[$];
   int               results_owed = 0;
   int               errors       = 0;
   int               hold_asks    = 0;
   int               hold_done    = 0;
   int               stall_left   = 0;
   bit               calm         = 1'b0;

   accumulator_cpu_execute_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Executes one instruction on the model state and returns the result word it produces.
   function automatic acx_pkg::rsp_type retire_instruction(input acx_pkg::req_type w);
      acx_pkg::rsp_type r;
      logic [15:0]      nxt;
      logic [15:0]      a;
      logic [15:0]      g;
      r = '0;
      if (m_halted || m_pc >= m_len) begin
         r.next_index = m_pc;
         r.acc_value  = m_acc;
         r.finished   = 1'b1;
         return r;
      end
      nxt = m_pc + 16'd1;
      a   = m_acc;
      g   = m_reg;
      case (w.operation)
         acx_pkg::OP_SET:    g = w.attribute;
         acx_pkg::OP_ADD:    a = a + g;
         acx_pkg::OP_SUB:    a = a - g;
         acx_pkg::OP_SHG:    a = a << 1;
         acx_pkg::OP_SHS:    a = a >> 1;
         acx_pkg::OP_LOR:    a = a | g;
         acx_pkg::OP_AND:    a = a & g;
         acx_pkg::OP_XOR:    a = a ^ g;
         acx_pkg::OP_NOT:    a = ~a;
         acx_pkg::OP_LDA:    a = m_mem[w.attribute];
         acx_pkg::OP_LDR:    g = m_mem[w.attribute];
         acx_pkg::OP_SAD:    m_mem[w.attribute] = a;
         acx_pkg::OP_SRD:    m_mem[w.attribute] = g;
         acx_pkg::OP_LPA:    a = m_mem[m_mem[w.attribute]];
         acx_pkg::OP_LPR:    g = m_mem[m_mem[w.attribute]];
         acx_pkg::OP_SAP:    m_mem[m_mem[w.attribute]] = a;
         acx_pkg::OP_SRP:    m_mem[m_mem[w.attribute]] = g;
         acx_pkg::OP_OUT: begin
            r.print_valid = 1'b1;
            r.print_value = m_mem[w.attribute];
         end
         acx_pkg::OP_INP:    m_mem[w.attribute] = w.input_value;
         acx_pkg::OP_GOT:    nxt = w.attribute + 16'd1;
         acx_pkg::OP_JM0:    if (a == 16'd0) nxt = w.attribute + 16'd1;
         acx_pkg::OP_JMA:    if (a == g) nxt = w.attribute + 16'd1;
         acx_pkg::OP_JMG:    if (a > g) nxt = w.attribute + 16'd1;
         acx_pkg::OP_JML:    if (a < g) nxt = w.attribute + 16'd1;
         acx_pkg::OP_JMS: begin
            // A call on a full stack loses its return index but still jumps.
            if (m_sp < acx_pkg::STACK_DEPTH) begin
               m_stack[acx_pkg::STK_AW'(m_sp)] = m_pc;
               m_sp++;
            end else begin
               r.stack_fault = 1'b1;
            end
            nxt = w.attribute + 16'd1;
         end
         acx_pkg::OP_RET: begin
            if (m_sp > 0) begin
               m_sp--;
               nxt = m_stack[acx_pkg::STK_AW'(m_sp)] + 16'd1;
            end else begin
               r.stack_fault = 1'b1;
            end
         end
         acx_pkg::OP_PHA: begin
            if (m_sp < acx_pkg::STACK_DEPTH) begin
               m_stack[acx_pkg::STK_AW'(m_sp)] = a;
               m_sp++;
            end else begin
               r.stack_fault = 1'b1;
            end
         end
         acx_pkg::OP_PLA: begin
            if (m_sp > 0) begin
               m_sp--;
               a = m_stack[acx_pkg::STK_AW'(m_sp)];
            end else begin
               a = 16'd0;
            end
         end
         acx_pkg::OP_BRK:    m_halted = 1'b1;
         acx_pkg::OP_CLR: begin
            a = 16'd0;
            g = 16'd0;
         end
         acx_pkg::OP_PUTSTR: begin
            r.char_valid = 1'b1;
            r.char_code  = a[7:0];
         end
         default: ;
      endcase
      m_acc        = a;
      m_reg        = g;
      m_pc         = nxt;
      r.next_index = nxt;
      r.acc_value  = a;
      r.finished   = m_halted || (nxt >= m_len);
      return r;
   endfunction

   function automatic acx_pkg::req_type make_random_word(input burst_style_type style);
      acx_pkg::req_type w;
      int               k;
      int               lim;
      k = $urandom_range(0, 99);
      if (style == FILL_STYLE && k < 80) begin
         w.operation = (k < 60) ? acx_pkg::OP_PHA : acx_pkg::OP_JMS;
      end else if (style == DRAIN_STYLE && k < 80) begin
         w.operation = (k < 50) ? acx_pkg::OP_PLA : acx_pkg::OP_RET;
      end else begin
         w.operation = 5'($urandom_range(0, 31));
         // A halt can never be undone, so it is saved for the end of the run.
         if (w.operation == acx_pkg::OP_BRK) w.operation = OP_UNUSED;
      end
      if (w.operation >= acx_pkg::OP_GOT && w.operation <= acx_pkg::OP_JMS) begin
         lim = int'(m_len) - 2;
         if (lim < 0) lim = 0;
         if (lim > 60000) lim = 60000;
         k = $urandom_range(0, 99);
         if (k < 8) w.attribute = 16'hFFFF;
         else if (k < 12) w.attribute = 16'($urandom_range(0, 60000));
         else w.attribute = 16'($urandom_range(0, lim));
      end else if ($urandom_range(0, 3) != 0) begin
         w.attribute = 16'($urandom_range(0, 31));
      end else if ($urandom_range(0, 1) == 0) begin
         w.attribute = 16'hFFE0 + 16'($urandom_range(0, 31));
      end else begin
         w.attribute = 16'($urandom);
      end
      // Small values make good pointers for the indirect accesses.
      if ($urandom_range(0, 1) == 0) w.input_value = 16'($urandom_range(0, 63));
      else w.input_value = 16'($urandom);
      return w;
   endfunction

   function automatic void add_step(input logic [4:0] op, input logic [15:0] attr,
                                    input logic [15:0] inval, input bit typed,
                                    input acx_pkg::rsp_type want);
      plan_row_type p;
      p.is_cfg           = 1'b0;
      p.typed            = typed;
      p.word.operation   = op;
      p.word.attribute   = attr;
      p.word.input_value = inval;
      p.cfg_value        = '0;
      p.want             = want;
      plan_rows.push_back(p);
   endfunction

   function automatic void add_length(input logic [15:0] value);
      plan_row_type p;
      p           = '{default: '0};
      p.is_cfg    = 1'b1;
      p.cfg_value = value;
      plan_rows.push_back(p);
   endfunction

   // Records the expected result and offers the word until it is taken.
   task automatic send_word(input acx_pkg::req_type w, input bit typed,
                            input acx_pkg::rsp_type want);
      acx_pkg::rsp_type model;
      int               gap;
      model = retire_instruction(w);
      pending_results.push_back(typed ? want : model);
      results_owed++;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // The register is only written once every result of earlier words has come back.
   task automatic write_length(input logic [15:0] value);
      req_valid <= 1'b0;
      wait (results_owed == 0);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      m_len = value;
   endtask

   task automatic run_rows(input int lo, input int hi);
      for (int i = lo; i < hi; i++) begin
         if (plan_rows[i].is_cfg) write_length(plan_rows[i].cfg_value);
         else send_word(plan_rows[i].word, plan_rows[i].typed, plan_rows[i].want);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_side
      acx_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result word %h expected none actual %h", $time, rsp_data, rsp_data);
               errors++;
            end else begin
               want = pending_results.pop_front();
               results_owed--;
               check_field("next_index", want.next_index, rsp_data.next_index);
               check_field("print_valid", 16'(want.print_valid), 16'(rsp_data.print_valid));
               check_field("print_value", want.print_value, rsp_data.print_value);
               check_field("char_valid", 16'(want.char_valid), 16'(rsp_data.char_valid));
               check_field("char_code", 16'(want.char_code), 16'(rsp_data.char_code));
               check_field("acc_value", want.acc_value, rsp_data.acc_value);
               check_field("finished", 16'(want.finished), 16'(rsp_data.finished));
               check_field("stack_fault", 16'(want.stack_fault), 16'(rsp_data.stack_fault));
            end
         end
         if (hold_done != hold_asks) begin
            hold_done  = hold_asks;
            stall_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int              split;
      int              executed;
      int              phase;
      int              n;
      int              stuck;
      int              t;
      logic [15:0]     len;
      burst_style_type style;
      for (int k = 0; k < acx_pkg::MEM_WORDS; k++) m_mem[acx_pkg::MEM_AW'(k)] = '0;

      add_step(acx_pkg::OP_OUT, 16'hFFFF, 16'h0000, 1'b1,
               '{16'd1, 1'b1, 16'd0, 1'b0, 8'd0, 16'd0, 1'b0, 1'b0});
      add_step(acx_pkg::OP_SET, 16'hFFFF, 16'hFFFF, 1'b1,
               '{16'd2, 1'b0, 16'd0, 1'b0, 8'd0, 16'd0, 1'b0, 1'b0});
      add_step(acx_pkg::OP_ADD, 16'h0000, 16'h0000, 1'b1,
               '{16'd3, 1'b0, 16'd0, 1'b0, 8'd0, 16'hFFFF, 1'b0, 1'b0});
      add_step(acx_pkg::OP_ADD,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_SHG,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_SHS,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_XOR,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_NOT,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_LOR,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_AND,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_SAD,    16'hFFFF, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_INP,    16'h0010, 16'hFFFF, 1'b0, '0);
      add_step(acx_pkg::OP_LPA,    16'h0010, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_SRP,    16'h0010, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_LDR,    16'hFFFF, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_SRD,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_LDA,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_LPR,    16'h0010, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_SAP,    16'h0010, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_PUTSTR, 16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_PHA,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_PLA,    16'h0000, 16'h0000, 1'b0, '0);
      // Pop and return on an empty stack.
      add_step(acx_pkg::OP_PLA,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_RET,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_JMS,    16'h0040, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_RET,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_JM0,    16'h0080, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_JMA,    16'h0090, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_JMG,    16'h00A0, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_JML,    16'h00B0, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_CLR,    16'h0000, 16'h0000, 1'b0, '0);
      add_step(OP_UNUSED,          16'hFFFF, 16'hFFFF, 1'b0, '0);
      // The jump target plus one wraps to index zero.
      add_step(acx_pkg::OP_GOT, 16'hFFFF, 16'h0000, 1'b1,
               '{16'd0, 1'b0, 16'd0, 1'b0, 8'd0, 16'd0, 1'b0, 1'b0});
      add_length(16'h0000);
      add_step(acx_pkg::OP_SET, 16'h1234, 16'h0000, 1'b1,
               '{16'd0, 1'b0, 16'd0, 1'b0, 8'd0, 16'd0, 1'b1, 1'b0});
      add_length(16'hFFFF);
      split = plan_rows.size();
      add_step(acx_pkg::OP_BRK, 16'h0000, 16'h0000, 1'b0, '0);
      add_step(acx_pkg::OP_SET, 16'h5555, 16'h5555, 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_rows(0, split);

      executed = 0;
      phase    = 0;
      while (executed < RANDOM_ITEMS) begin
         t = int'(m_pc) + $urandom_range(30, 400);
         if (t > 65535) t = 65535;
         if (phase == 0) len = 16'hFFFF;
         else if (phase % 7 == 3) len = 16'h0000;
         else if ($urandom_range(0, 3) == 0) len = 16'hFFFF;
         else len = 16'(t);
         write_length(len);
         t = $urandom_range(0, 9);
         if (phase == 0 || t < 6) style = MIX_STYLE;
         else if (t < 8) style = FILL_STYLE;
         else style = DRAIN_STYLE;
         if (phase == 0) begin
            // Results pile up behind a long receiver stall while words keep coming.
            hold_asks <= hold_asks + 1;
            n = 150;
         end else if (len == 16'h0000) begin
            n = 3;
         end else if (style == FILL_STYLE) begin
            n = acx_pkg::STACK_DEPTH + 84;
         end else if (style == DRAIN_STYLE) begin
            n = m_sp + 12;
         end else begin
            n = $urandom_range(40, 150);
         end
         stuck = 0;
         for (int i = 0; i < n && stuck < 3; i++) begin
            if (m_halted || m_pc >= m_len) stuck++;
            else executed++;
            if (executed >= RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
            send_word(make_random_word(style), 1'b0, '0);
         end
         phase++;
      end

      run_rows(split, plan_rows.size());
      req_valid <= 1'b0;
      wait (results_owed == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 10);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/acx_pkg.sv
rtl/core/accumulator_cpu_execute_top.sv
tb/sv/accumulator_cpu_execute_top_tb.sv
